// File: rtl/tcs_pkg.sv
// shared constants, codes and control/status types of the text console
package tcs_pkg;

    // store geometry (HISTORY_DEPTH and MAX_COLUMNS are powers of two)
    localparam int HISTORY_DEPTH = 512;
    localparam int MAX_COLUMNS   = 256;
    localparam int MAX_LINES     = 128;
    localparam int LINE_W        = $clog2(HISTORY_DEPTH);
    localparam int COL_W         = $clog2(MAX_COLUMNS);
    localparam int ADDR_W        = LINE_W + COL_W;
    localparam int CELLS         = HISTORY_DEPTH * MAX_COLUMNS;
    localparam int CELL_W        = 16;

    // character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // item modes
    localparam logic [2:0] MODE_PUT  = 3'd0;
    localparam logic [2:0] MODE_BACK = 3'd1;
    localparam logic [2:0] MODE_FWD  = 3'd2;
    localparam logic [2:0] MODE_CLR  = 3'd3;
    localparam logic [2:0] MODE_READ = 3'd4;

    // register indexes
    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_LINES = 2'd1;
    localparam logic [1:0] REG_FG    = 2'd2;
    localparam logic [1:0] REG_BG    = 2'd3;

    // register reset values
    localparam logic [8:0] RESET_COLS  = 9'd80;
    localparam logic [7:0] RESET_LINES = 8'd25;
    localparam logic [3:0] RESET_FG    = 4'd15;
    localparam logic [3:0] RESET_BG    = 4'd0;

    // memory address select
    typedef logic [1:0] asel_t;
    localparam asel_t ASEL_ALL    = 2'd0;
    localparam asel_t ASEL_HEAD   = 2'd1;
    localparam asel_t ASEL_CURSOR = 2'd2;
    localparam asel_t ASEL_VIEW   = 2'd3;

    // memory write data select
    typedef logic [1:0] wsel_t;
    localparam wsel_t WSEL_FILL = 2'd0;
    localparam wsel_t WSEL_INIT = 2'd1;
    localparam wsel_t WSEL_PUT  = 2'd2;
    localparam wsel_t WSEL_ZERO = 2'd3;

    typedef struct packed {
        logic  latch;
        logic  leave_scroll;
        logic  newline;
        logic  bs_step;
        logic  bs_back;
        logic  bs_set;
        logic  tab;
        logic  cr;
        logic  scroll_bk;
        logic  scroll_fw;
        logic  clear_regs;
        logic  put_adv;
        logic  cnt_inc;
        logic  scan_issue;
        logic  load_cell;
        logic  read_blank;
        logic  load_out;
        logic  ram_we;
        asel_t asel;
        wsel_t wsel;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       is_nl;
        logic       is_bs;
        logic       is_tab;
        logic       is_cr;
        logic       col_zero;
        logic       can_back;
        logic       line_full;
        logic       read_blank;
        logic       all_last;
        logic       line_last;
        logic       scan_last;
        logic       out_busy;
    } stat_t;

endpackage

// File: rtl/tcs_ram.sv
// generic single-write, single-read memory with registered read data
module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tcs_ctrl.sv
// controller state machine sequencing console items over the datapath
module tcs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  tcs_pkg::stat_t stat,
    output tcs_pkg::cmd_t  cmd,
    input  logic           in_valid,
    output logic           in_ready
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_LCLR  = 4'd3;
    localparam logic [3:0] S_FILL  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_SCEND = 4'd6;
    localparam logic [3:0] S_BSSET = 4'd7;
    localparam logic [3:0] S_ZRD   = 4'd8;
    localparam logic [3:0] S_ZWR   = 4'd9;
    localparam logic [3:0] S_PWR   = 4'd10;
    localparam logic [3:0] S_RD    = 4'd11;
    localparam logic [3:0] S_RDW   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       printable;

    assign printable = !stat.is_nl && !stat.is_bs && !stat.is_tab && !stat.is_cr;
    assign in_ready  = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        cmd.asel   = tcs_pkg::ASEL_ALL;
        cmd.wsel   = tcs_pkg::WSEL_FILL;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.ram_we  = 1'b1;
                cmd.wsel    = tcs_pkg::WSEL_INIT;
                cmd.cnt_inc = 1'b1;
                if (stat.all_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_FIN;
                case (stat.mode)
                    tcs_pkg::MODE_PUT:
                    begin
                        cmd.leave_scroll = 1'b1;
                        if (stat.is_nl)
                        begin
                            cmd.newline = 1'b1;
                            state_next  = S_LCLR;
                        end
                        else if (stat.is_bs)
                        begin
                            if (!stat.col_zero)
                            begin
                                cmd.bs_step = 1'b1;
                                state_next  = S_ZRD;
                            end
                            else if (stat.can_back)
                            begin
                                cmd.bs_back = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        else if (stat.is_tab)
                        begin
                            cmd.tab = 1'b1;
                        end
                        else if (stat.is_cr)
                        begin
                            cmd.cr = 1'b1;
                        end
                        else if (stat.line_full)
                        begin
                            cmd.newline = 1'b1;
                            state_next  = S_LCLR;
                        end
                        else
                        begin
                            state_next = S_PWR;
                        end
                    end
                    tcs_pkg::MODE_BACK: cmd.scroll_bk = 1'b1;
                    tcs_pkg::MODE_FWD:  cmd.scroll_fw = 1'b1;
                    tcs_pkg::MODE_CLR:
                    begin
                        cmd.clear_regs = 1'b1;
                        state_next     = S_FILL;
                    end
                    tcs_pkg::MODE_READ:
                    begin
                        if (stat.read_blank)
                        begin
                            cmd.read_blank = 1'b1;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_LCLR:
            begin
                cmd.ram_we  = 1'b1;
                cmd.asel    = tcs_pkg::ASEL_HEAD;
                cmd.cnt_inc = 1'b1;
                if (stat.line_last)
                begin
                    state_next = printable ? S_PWR : S_FIN;
                end
            end
            S_FILL:
            begin
                cmd.ram_we  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.all_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                cmd.asel       = tcs_pkg::ASEL_HEAD;
                cmd.scan_issue = 1'b1;
                cmd.cnt_inc    = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_SCEND;
                end
            end
            S_SCEND: state_next = S_BSSET;
            S_BSSET:
            begin
                cmd.bs_set = 1'b1;
                state_next = S_ZRD;
            end
            S_ZRD:
            begin
                cmd.asel   = tcs_pkg::ASEL_CURSOR;
                state_next = S_ZWR;
            end
            S_ZWR:
            begin
                cmd.ram_we = 1'b1;
                cmd.asel   = tcs_pkg::ASEL_CURSOR;
                cmd.wsel   = tcs_pkg::WSEL_ZERO;
                state_next = S_FIN;
            end
            S_PWR:
            begin
                cmd.ram_we  = 1'b1;
                cmd.asel    = tcs_pkg::ASEL_CURSOR;
                cmd.wsel    = tcs_pkg::WSEL_PUT;
                cmd.put_adv = 1'b1;
                state_next  = S_FIN;
            end
            S_RD:
            begin
                cmd.asel   = tcs_pkg::ASEL_VIEW;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                cmd.load_cell = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/tcs_datapath.sv
// console datapath: registers, cursor and ring arithmetic, memory port and result register
module tcs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcs_pkg::cmd_t                 cmd,
    output tcs_pkg::stat_t                stat,
    input  logic [31:0]                   in_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_idx,
    input  logic [8:0]                    cfg_wdata,
    output logic                          ram_we,
    output logic [tcs_pkg::ADDR_W-1:0]    ram_addr,
    output logic [tcs_pkg::CELL_W-1:0]    ram_wdata,
    input  logic [tcs_pkg::CELL_W-1:0]    ram_rdata,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [47:0]                   out_data
);

    // item fields
    logic [2:0] mode_reg;
    logic [7:0] char_reg;
    logic [6:0] row_reg;
    logic [7:0] colin_reg;

    // configuration
    logic [8:0] cols_reg;
    logic [7:0] lines_reg;
    logic [3:0] fg_reg;
    logic [3:0] bg_reg;

    // console state
    logic [8:0]                  ccol_reg;
    logic [6:0]                  cline_reg;
    logic [tcs_pkg::LINE_W-1:0]  head_reg;
    logic [8:0]                  scroll_reg;
    logic                        wrapped_reg;
    logic [tcs_pkg::ADDR_W-1:0]  cnt_reg;
    logic [8:0]                  lastp1_reg;
    logic                        pend_v_reg;
    logic [tcs_pkg::COL_W-1:0]   pend_idx_reg;
    logic                        chg_reg;
    logic [15:0]                 cell_reg;

    // result register
    logic        ovalid_reg;
    logic [15:0] ocell_reg;
    logic [8:0]  occol_reg;
    logic [6:0]  ocline_reg;
    logic [8:0]  oscroll_reg;
    logic        ochg_reg;

    logic [8:0]                 cols_eff;
    logic [7:0]                 lines_eff;
    logic [tcs_pkg::LINE_W-1:0] head_inc;
    logic [tcs_pkg::LINE_W-1:0] head_dec;
    logic [9:0]                 tab_sum;
    logic [9:0]                 tab_n;
    logic [9:0]                 total;
    logic [9:0]                 limit;
    logic [11:0]                logical;
    logic                       view_blank;
    logic [15:0]                blank_cell;

    // clamped register values
    always_comb
    begin
        if (cols_reg == 9'd0)
        begin
            cols_eff = 9'd1;
        end
        else if (cols_reg > 9'(tcs_pkg::MAX_COLUMNS))
        begin
            cols_eff = 9'(tcs_pkg::MAX_COLUMNS);
        end
        else
        begin
            cols_eff = cols_reg;
        end
        if (lines_reg == 8'd0)
        begin
            lines_eff = 8'd1;
        end
        else if (lines_reg > 8'(tcs_pkg::MAX_LINES))
        begin
            lines_eff = 8'(tcs_pkg::MAX_LINES);
        end
        else
        begin
            lines_eff = lines_reg;
        end
    end

    // ring and cursor arithmetic
    assign head_inc = (head_reg == tcs_pkg::LINE_W'(tcs_pkg::HISTORY_DEPTH - 1)) ?
                      '0 : head_reg + 1'b1;
    assign head_dec = head_reg - 1'b1;
    assign tab_sum  = {1'b0, ccol_reg} + 10'd4;
    assign tab_n    = {tab_sum[9:2], 2'b00};
    assign total    = wrapped_reg ? 10'(tcs_pkg::HISTORY_DEPTH) : 10'(head_reg) + 10'd1;
    assign limit    = (total > {2'b00, lines_eff}) ? total - {2'b00, lines_eff} : 10'd0;

    // viewport row to ring line
    assign logical    = 12'(head_reg) - 12'(lines_eff) + 12'd1 - 12'(scroll_reg)
                        + 12'(row_reg);
    assign blank_cell = {bg_reg, fg_reg, tcs_pkg::CH_SPACE};
    assign view_blank = ({1'b0, row_reg} >= lines_eff) || ({1'b0, colin_reg} >= cols_eff)
                        || (!wrapped_reg && (logical[11] || (logical > 12'(head_reg))));

    // status to the controller
    always_comb
    begin
        stat.mode       = mode_reg;
        stat.is_nl      = (char_reg == tcs_pkg::CH_NEWLINE);
        stat.is_bs      = (char_reg == tcs_pkg::CH_BACKSPACE);
        stat.is_tab     = (char_reg == tcs_pkg::CH_TAB);
        stat.is_cr      = (char_reg == tcs_pkg::CH_RETURN);
        stat.col_zero   = (ccol_reg == 9'd0);
        stat.can_back   = (cline_reg != 7'd0) || (head_reg != '0);
        stat.line_full  = (ccol_reg >= cols_eff);
        stat.read_blank = view_blank;
        stat.all_last   = (cnt_reg == tcs_pkg::ADDR_W'(tcs_pkg::CELLS - 1));
        stat.line_last  = (cnt_reg[tcs_pkg::COL_W-1:0] == '1);
        stat.scan_last  = (9'(cnt_reg[tcs_pkg::COL_W-1:0]) == cols_eff - 9'd1);
        stat.out_busy   = ovalid_reg && !out_ready;
    end

    // memory address and write data
    always_comb
    begin
        case (cmd.asel)
            tcs_pkg::ASEL_ALL:    ram_addr = cnt_reg;
            tcs_pkg::ASEL_HEAD:   ram_addr = {head_reg, cnt_reg[tcs_pkg::COL_W-1:0]};
            tcs_pkg::ASEL_CURSOR: ram_addr = {head_reg, ccol_reg[tcs_pkg::COL_W-1:0]};
            tcs_pkg::ASEL_VIEW:   ram_addr = {logical[tcs_pkg::LINE_W-1:0],
                                              tcs_pkg::COL_W'(colin_reg)};
            default:              ram_addr = cnt_reg;
        endcase
        case (cmd.wsel)
            tcs_pkg::WSEL_FILL: ram_wdata = {bg_reg, fg_reg, 8'd0};
            tcs_pkg::WSEL_INIT: ram_wdata = {tcs_pkg::RESET_BG, tcs_pkg::RESET_FG, 8'd0};
            tcs_pkg::WSEL_PUT:  ram_wdata = {bg_reg, fg_reg, char_reg};
            tcs_pkg::WSEL_ZERO: ram_wdata = {ram_rdata[15:8], 8'd0};
            default:            ram_wdata = {bg_reg, fg_reg, 8'd0};
        endcase
    end
    assign ram_we = cmd.ram_we;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= in_data[2:0];
            char_reg  <= in_data[10:3];
            row_reg   <= in_data[17:11];
            colin_reg <= in_data[25:18];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= tcs_pkg::RESET_COLS;
            lines_reg <= tcs_pkg::RESET_LINES;
            fg_reg    <= tcs_pkg::RESET_FG;
            bg_reg    <= tcs_pkg::RESET_BG;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                tcs_pkg::REG_COLS:  cols_reg  <= cfg_wdata;
                tcs_pkg::REG_LINES: lines_reg <= cfg_wdata[7:0];
                tcs_pkg::REG_FG:    fg_reg    <= cfg_wdata[3:0];
                tcs_pkg::REG_BG:    bg_reg    <= cfg_wdata[3:0];
                default:            cols_reg  <= cols_reg;
            endcase
        end
    end

    // cursor, head, scroll and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccol_reg    <= '0;
            cline_reg   <= '0;
            head_reg    <= '0;
            scroll_reg  <= '0;
            wrapped_reg <= 1'b0;
            cnt_reg     <= '0;
            lastp1_reg  <= '0;
            pend_v_reg  <= 1'b0;
            chg_reg     <= 1'b0;
        end
        else
        begin
            pend_v_reg <= cmd.scan_issue;
            if (cmd.latch)
            begin
                chg_reg <= 1'b0;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.leave_scroll && scroll_reg != 9'd0)
            begin
                scroll_reg <= '0;
                chg_reg    <= 1'b1;
            end
            // newline: advance head and start the line clear
            if (cmd.newline)
            begin
                head_reg <= head_inc;
                if (head_inc == '0)
                begin
                    wrapped_reg <= 1'b1;
                end
                ccol_reg <= '0;
                if ((8'(cline_reg) + 8'd1) < lines_eff)
                begin
                    cline_reg <= cline_reg + 7'd1;
                end
                cnt_reg <= '0;
                chg_reg <= 1'b1;
            end
            if (cmd.bs_step)
            begin
                ccol_reg <= ccol_reg - 9'd1;
                chg_reg  <= 1'b1;
            end
            // backspace at column zero: rejoin the previous line
            if (cmd.bs_back)
            begin
                if (cline_reg != 7'd0)
                begin
                    cline_reg <= cline_reg - 7'd1;
                end
                head_reg   <= head_dec;
                cnt_reg    <= '0;
                lastp1_reg <= '0;
                chg_reg    <= 1'b1;
            end
            if (pend_v_reg && ram_rdata[7:0] != 8'd0)
            begin
                lastp1_reg <= 9'(pend_idx_reg) + 9'd1;
            end
            if (cmd.bs_set)
            begin
                ccol_reg <= (lastp1_reg < cols_eff) ? lastp1_reg : cols_eff - 9'd1;
            end
            if (cmd.tab)
            begin
                ccol_reg <= (tab_n > {1'b0, cols_eff}) ? cols_eff : tab_n[8:0];
            end
            if (cmd.cr)
            begin
                ccol_reg <= '0;
            end
            if (cmd.put_adv)
            begin
                ccol_reg <= ccol_reg + 9'd1;
                chg_reg  <= 1'b1;
            end
            if (cmd.scroll_bk && {1'b0, scroll_reg} < limit)
            begin
                scroll_reg <= scroll_reg + 9'd1;
                chg_reg    <= 1'b1;
            end
            if (cmd.scroll_fw && scroll_reg != 9'd0)
            begin
                scroll_reg <= scroll_reg - 9'd1;
                chg_reg    <= 1'b1;
            end
            if (cmd.clear_regs)
            begin
                ccol_reg    <= '0;
                cline_reg   <= '0;
                head_reg    <= '0;
                scroll_reg  <= '0;
                wrapped_reg <= 1'b0;
                cnt_reg     <= '0;
                chg_reg     <= 1'b1;
            end
        end
    end

    // scan index and read cell payload
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= cnt_reg[tcs_pkg::COL_W-1:0];
        if (cmd.latch)
        begin
            cell_reg <= '0;
        end
        else if (cmd.read_blank)
        begin
            cell_reg <= blank_cell;
        end
        else if (cmd.load_cell)
        begin
            cell_reg <= (ram_rdata[7:0] == 8'd0) ?
                        {ram_rdata[15:8], tcs_pkg::CH_SPACE} : ram_rdata;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            ocell_reg   <= cell_reg;
            occol_reg   <= ccol_reg;
            ocline_reg  <= cline_reg;
            oscroll_reg <= scroll_reg;
            ochg_reg    <= chg_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = {6'd0, ochg_reg, oscroll_reg, ocline_reg, occol_reg, ocell_reg};

endmodule

// File: rtl/text_console_scrollback.sv
// top level of the text console with scrollback history
//
// Items enter on s_tdata (mode, char_code, screen_row, screen_col) and each
// gives exactly one result on m_tdata. Configuration registers are written on
// the cfg channel (index 0 columns, 1 screen lines, 2 fg colour, 3 bg colour),
// which is always ready; write them only while the block is idle.
// One item is worked on at a time; s_tready is high only when no item is in
// progress and rises in the cycle after the result is loaded. Each item works
// through the single port of the history memory (512 lines of 256 cells):
//   tab, return, scroll, unknown mode, read outside the view or of an
//   unwritten row: no memory access
//   printable char: cell write; plain backspace step: cell read and clear
//   read cell: cell read; newline: line clear sweep
//   printable on a full line: line clear sweep, then cell write
//   backspace joining the previous line: line scan, then cell read and clear
//   clear: whole store sweep
// After reset the block sweeps the whole store with blank cells before
// s_tready first rises; config writes are taken during the sweep.
// A result waits in the output register while m_tready is low; the next item
// is still accepted and runs, holding only at its end until the register frees.
module text_console_scrollback (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // mode[2:0], char_code[10:3], screen_row[17:11],
                                    // screen_col[25:18], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // cell_char[7:0], cell_fg[11:8], cell_bg[15:12],
                                    // cursor_col[24:16], cursor_row[31:25],
                                    // scroll_pos[40:32], view_changed[41], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    tcs_pkg::cmd_t                   cmd;
    tcs_pkg::stat_t                  stat;
    logic                            ram_we;
    logic [tcs_pkg::ADDR_W-1:0]      ram_addr;
    logic [tcs_pkg::CELL_W-1:0]      ram_wdata;
    logic [tcs_pkg::CELL_W-1:0]      ram_rdata;

    assign cfg_ready = 1'b1;

    // sequencer
    tcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .cmd      (cmd),
        .in_valid (s_tvalid),
        .in_ready (s_tready)
    );

    // datapath
    tcs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    // history store
    tcs_ram #(
        .WIDTH (tcs_pkg::CELL_W),
        .DEPTH (tcs_pkg::CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_out && m_tvalid && !m_tready))
        else $error("result register overwritten while full");
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && ram_we))
        else $error("memory written while idle");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in progress");
`endif

endmodule
